[hw/rtl/segment_box_first_hit_assert.svh]
// Assertion macros for the segment/box first-hit checker.
`ifndef SEGMENT_BOX_FIRST_HIT_ASSERT_SVH
`define SEGMENT_BOX_FIRST_HIT_ASSERT_SVH

// Clocked property, disabled while in reset.
`define SBFH_ASSERT(lbl, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("sbfh check failed");

// Condition that must never be seen while out of reset.
`define SBFH_NEVER(lbl, cond) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("sbfh forbidden condition");

`endif

[hw/rtl/sbfh_pkg.sv]
// Types and constants for the segment/box first-hit block.
package sbfh_pkg;

    localparam int COORD_W  = 16;
    localparam int T_FRAC_W = 16;
    localparam int T_W      = T_FRAC_W + 1;
    localparam int PROD_W   = 2 * COORD_W;
    // input reg, product, point divider, check, 4 select stages, t divider
    localparam int LATENCY  = 7 + COORD_W + T_W;

    typedef logic signed [COORD_W-1:0] coord_t;

    typedef struct packed {
        coord_t start_x;
        coord_t start_y;
        coord_t end_x;
        coord_t end_y;
        coord_t box_min_x;
        coord_t box_min_y;
        coord_t box_max_x;
        coord_t box_max_y;
    } seg_t;

    typedef struct packed {
        logic           hit;
        logic [T_W-1:0] hit_t;
        logic [1:0]     hit_side;
    } res_t;

    // Per-side data carried through the point divider.
    typedef struct packed {
        logic               ok;      // delta nonzero and t in [0,1]
        logic               box_ok;  // own-axis bounds not inverted
        logic [COORD_W-1:0] un;
        logic [COORD_W-1:0] ud;
        logic               neg;     // other-axis delta negative
        coord_t             s_ot;
        coord_t             lo_ot;
        coord_t             hi_ot;
        logic [1:0]         side;
    } side_t;

    typedef struct packed {
        logic               valid;
        logic [COORD_W-1:0] un;
        logic [COORD_W-1:0] ud;
        logic [1:0]         side;
    } cand_t;

    typedef struct packed {
        logic       hit;
        logic [1:0] side;
    } tag_t;

endpackage

[hw/rtl/sbfh_div_pipe.sv]
// Pipelined restoring divider, one quotient bit per stage.
module sbfh_div_pipe #(
    parameter int DVD_W = 32,
    parameter int DIV_W = 16,
    parameter int Q_W   = 16,
    parameter int PAY_W = 1
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    input  logic [DVD_W-1:0] in_dividend,
    input  logic [DIV_W-1:0] in_divisor,
    input  logic [PAY_W-1:0] in_pay,
    output logic             out_valid,
    output logic [Q_W-1:0]   out_quot,
    output logic [PAY_W-1:0] out_pay
);

    // quotient must fit in Q_W bits: upper dividend part below divisor
    logic [DIV_W-1:0] rem_reg [Q_W];
    logic [Q_W-1:0]   quo_reg [Q_W];
    logic [DIV_W-1:0] dvs_reg [Q_W];
    logic [PAY_W-1:0] pay_reg [Q_W];
    logic [Q_W-1:0]   vld_reg;

    for (genvar j = 0; j < Q_W; j++) begin : g_stage
        logic [DIV_W-1:0] rem_prev;
        logic [Q_W-1:0]   quo_prev;
        logic [DIV_W-1:0] dvs_prev;
        logic [PAY_W-1:0] pay_prev;
        logic             vld_prev;
        logic [DIV_W:0]   trial;
        logic             ge;
        logic [DIV_W-1:0] rem_next;
        logic [Q_W-1:0]   quo_next;

        if (j == 0) begin : g_first
            assign rem_prev = DIV_W'(in_dividend[DVD_W-1:Q_W]);
            assign quo_prev = in_dividend[Q_W-1:0];
            assign dvs_prev = in_divisor;
            assign pay_prev = in_pay;
            assign vld_prev = in_valid;
        end else begin : g_next
            assign rem_prev = rem_reg[j-1];
            assign quo_prev = quo_reg[j-1];
            assign dvs_prev = dvs_reg[j-1];
            assign pay_prev = pay_reg[j-1];
            assign vld_prev = vld_reg[j-1];
        end

        assign trial    = {rem_prev, quo_prev[Q_W-1]};
        assign ge       = trial >= {1'b0, dvs_prev};
        assign rem_next = ge ? DIV_W'(trial - {1'b0, dvs_prev}) : trial[DIV_W-1:0];
        assign quo_next = {quo_prev[Q_W-2:0], ge};

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                vld_reg[j] <= 1'b0;
            end
            else
            begin
                vld_reg[j] <= vld_prev;
            end
        end

        always_ff @(posedge clk)
        begin
            rem_reg[j] <= rem_next;
            quo_reg[j] <= quo_next;
            dvs_reg[j] <= dvs_prev;
            pay_reg[j] <= pay_prev;
        end
    end

    assign out_valid = vld_reg[Q_W-1];
    assign out_quot  = quo_reg[Q_W-1];
    assign out_pay   = pay_reg[Q_W-1];

endmodule

[hw/rtl/segment_box_first_hit.sv]
// Top level: first side of a closed box crossed by a 2D integer segment.
//
//  channel   | handshake        | beat
//  ----------+------------------+---------------------------------------
//  input     | start / busy     | seg : segment end points and box bounds
//  result    | done (strobe)    | res : hit, hit_t (Q1.16), hit_side
//
//  One beat in per cycle; busy is never raised, the pipeline has no stalls.
//  Each beat gives one result and passes through, in order:
//  setup, product, a 16-stage point divider, containment, four select
//  stages and a 17-stage divider for t. The two dividers set the depth.
//  Reset clears only the valid bits of the stages; data registers are free.
//  The receiver cannot stall: done is a one-cycle strobe.
module segment_box_first_hit (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  sbfh_pkg::seg_t seg,
    output logic          done,
    output sbfh_pkg::res_t res
);

    localparam int CW = sbfh_pkg::COORD_W;
    localparam int FW = sbfh_pkg::T_FRAC_W;
    localparam int PW = sbfh_pkg::PROD_W;

    assign busy = 1'b0;

    logic accept;
    assign accept = start && !busy;

    // axis 0 = x, axis 1 = y
    sbfh_pkg::coord_t s_v  [2];
    sbfh_pkg::coord_t e_v  [2];
    sbfh_pkg::coord_t lo_v [2];
    sbfh_pkg::coord_t hi_v [2];

    assign s_v[0]  = seg.start_x;
    assign s_v[1]  = seg.start_y;
    assign e_v[0]  = seg.end_x;
    assign e_v[1]  = seg.end_y;
    assign lo_v[0] = seg.box_min_x;
    assign lo_v[1] = seg.box_min_y;
    assign hi_v[0] = seg.box_max_x;
    assign hi_v[1] = seg.box_max_y;

    // ---- stage A: per-side deltas, t numerator/denominator, range test ----
    sbfh_pkg::side_t  a_side_next  [4];
    logic [CW-1:0]    a_odmag_next [4];
    sbfh_pkg::side_t  a_side_reg   [4];
    logic [CW-1:0]    a_odmag_reg  [4];
    logic             a_vld_reg;

    for (genvar k = 0; k < 4; k++) begin : g_setup
        localparam int AX = k / 2;
        localparam int OT = 1 - AX;

        sbfh_pkg::coord_t bound;
        logic signed [CW:0] d;
        logic signed [CW:0] num;
        logic signed [CW:0] num_a;
        logic signed [CW:0] od;
        logic [CW-1:0]      dmag;

        assign bound = ((k % 2) == 1) ? hi_v[AX] : lo_v[AX];
        assign d     = (CW+1)'(e_v[AX]) - (CW+1)'(s_v[AX]);
        assign num   = (CW+1)'(bound) - (CW+1)'(s_v[AX]);
        assign od    = (CW+1)'(e_v[OT]) - (CW+1)'(s_v[OT]);
        // flip signs so the denominator is positive
        assign num_a = d[CW] ? -num : num;
        assign dmag  = d[CW] ? CW'(-d) : d[CW-1:0];

        always_comb
        begin
            a_side_next[k].ok     = (d != '0) && !num_a[CW] && (num_a[CW-1:0] <= dmag);
            a_side_next[k].box_ok = lo_v[AX] <= hi_v[AX];
            a_side_next[k].un     = num_a[CW-1:0];
            a_side_next[k].ud     = dmag;
            a_side_next[k].neg    = od[CW];
            a_side_next[k].s_ot   = s_v[OT];
            a_side_next[k].lo_ot  = lo_v[OT];
            a_side_next[k].hi_ot  = hi_v[OT];
            a_side_next[k].side   = 2'(k);
            a_odmag_next[k]       = od[CW] ? CW'(-od) : od[CW-1:0];
        end
    end

    // ---- stage B: |other delta| * numerator ----
    logic [PW-1:0]    b_prod_reg [4];
    sbfh_pkg::side_t  b_side_reg [4];
    logic             b_vld_reg;

    // ---- point dividers: |od| * num / den, truncated ----
    logic             dv_valid [4];
    logic [CW-1:0]    dv_mag   [4];
    sbfh_pkg::side_t  dv_side  [4];

    for (genvar k = 0; k < 4; k++) begin : g_pdiv
        logic [$bits(sbfh_pkg::side_t)-1:0] pay_out;

        sbfh_div_pipe #(
            .DVD_W (PW),
            .DIV_W (CW),
            .Q_W   (CW),
            .PAY_W ($bits(sbfh_pkg::side_t))
        ) u_pdiv (
            .clk         (clk),
            .rst_n       (rst_n),
            .in_valid    (b_vld_reg),
            .in_dividend (b_prod_reg[k]),
            .in_divisor  (b_side_reg[k].ud),
            .in_pay      (b_side_reg[k]),
            .out_valid   (dv_valid[k]),
            .out_quot    (dv_mag[k]),
            .out_pay     (pay_out)
        );

        assign dv_side[k] = sbfh_pkg::side_t'(pay_out);
    end

    // ---- stage C: crossing point and closed-box containment ----
    sbfh_pkg::cand_t  c_cand_next [4];
    sbfh_pkg::cand_t  c_cand_reg  [4];
    logic             c_vld_reg;

    for (genvar k = 0; k < 4; k++) begin : g_hit
        logic signed [CW+1:0] mag_s;
        logic signed [CW+1:0] pt;
        logic                 in_box;

        assign mag_s  = $signed({2'b00, dv_mag[k]});
        assign pt     = dv_side[k].neg ? (CW+2)'(dv_side[k].s_ot) - mag_s
                                       : (CW+2)'(dv_side[k].s_ot) + mag_s;
        assign in_box = (pt >= (CW+2)'(dv_side[k].lo_ot))
                     && (pt <= (CW+2)'(dv_side[k].hi_ot));

        always_comb
        begin
            c_cand_next[k].valid = dv_side[k].ok && dv_side[k].box_ok && in_box;
            c_cand_next[k].un    = dv_side[k].un;
            c_cand_next[k].ud    = dv_side[k].ud;
            c_cand_next[k].side  = dv_side[k].side;
        end
    end

    // ---- stages D/E: pairwise t compare (0 vs 1, 2 vs 3) ----
    // later side wins if the earlier is invalid or on strictly smaller t: un_b*ud_a < un_a*ud_b
    sbfh_pkg::cand_t  d_cand_reg [4];
    logic [PW-1:0]    d_pb_reg   [2];
    logic [PW-1:0]    d_pa_reg   [2];
    logic             d_vld_reg;

    sbfh_pkg::cand_t  e_win_next [2];
    sbfh_pkg::cand_t  e_win_reg  [2];
    logic             e_vld_reg;

    for (genvar p = 0; p < 2; p++) begin : g_pair
        always_comb
        begin
            if (d_cand_reg[2*p+1].valid
                && (!d_cand_reg[2*p].valid || (d_pb_reg[p] < d_pa_reg[p])))
            begin
                e_win_next[p] = d_cand_reg[2*p+1];
            end
            else
            begin
                e_win_next[p] = d_cand_reg[2*p];
            end
        end
    end

    // ---- stages F/G: final compare between the pair winners ----
    sbfh_pkg::cand_t  f_win_reg [2];
    logic [PW-1:0]    f_pb_reg;
    logic [PW-1:0]    f_pa_reg;
    logic             f_vld_reg;

    sbfh_pkg::cand_t  g_win_next;
    sbfh_pkg::cand_t  g_win_reg;
    logic             g_vld_reg;

    always_comb
    begin
        if (f_win_reg[1].valid && (!f_win_reg[0].valid || (f_pb_reg < f_pa_reg)))
        begin
            g_win_next = f_win_reg[1];
        end
        else
        begin
            g_win_next = f_win_reg[0];
        end
    end

    // ---- t divider: (un << FW) / ud; zero dividend when nothing hit ----
    logic [CW+FW-1:0]     t_dividend;
    logic [CW-1:0]        t_divisor;
    sbfh_pkg::tag_t       t_tag_in;
    logic [$bits(sbfh_pkg::tag_t)-1:0] t_tag_out;
    sbfh_pkg::tag_t       t_tag;

    assign t_dividend     = g_win_reg.valid ? {g_win_reg.un, FW'(0)} : '0;
    assign t_divisor      = g_win_reg.valid ? g_win_reg.ud : CW'(1);
    assign t_tag_in.hit   = g_win_reg.valid;
    assign t_tag_in.side  = g_win_reg.valid ? g_win_reg.side : 2'd0;

    sbfh_div_pipe #(
        .DVD_W (CW + FW),
        .DIV_W (CW),
        .Q_W   (sbfh_pkg::T_W),
        .PAY_W ($bits(sbfh_pkg::tag_t))
    ) u_tdiv (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (g_vld_reg),
        .in_dividend (t_dividend),
        .in_divisor  (t_divisor),
        .in_pay      (t_tag_in),
        .out_valid   (done),
        .out_quot    (res.hit_t),
        .out_pay     (t_tag_out)
    );

    assign t_tag        = sbfh_pkg::tag_t'(t_tag_out);
    assign res.hit      = t_tag.hit;
    assign res.hit_side = t_tag.side;

    // ---- valid bits ----
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_vld_reg <= 1'b0;
            b_vld_reg <= 1'b0;
            c_vld_reg <= 1'b0;
            d_vld_reg <= 1'b0;
            e_vld_reg <= 1'b0;
            f_vld_reg <= 1'b0;
            g_vld_reg <= 1'b0;
        end
        else
        begin
            a_vld_reg <= accept;
            b_vld_reg <= a_vld_reg;
            c_vld_reg <= dv_valid[0];
            d_vld_reg <= c_vld_reg;
            e_vld_reg <= d_vld_reg;
            f_vld_reg <= e_vld_reg;
            g_vld_reg <= f_vld_reg;
        end
    end

    // ---- data registers ----
    always_ff @(posedge clk)
    begin
        for (int k = 0; k < 4; k++)
        begin
            a_side_reg[k]  <= a_side_next[k];
            a_odmag_reg[k] <= a_odmag_next[k];
            b_side_reg[k]  <= a_side_reg[k];
            b_prod_reg[k]  <= PW'(a_odmag_reg[k]) * PW'(a_side_reg[k].un);
            c_cand_reg[k]  <= c_cand_next[k];
            d_cand_reg[k]  <= c_cand_reg[k];
        end
        for (int p = 0; p < 2; p++)
        begin
            d_pb_reg[p]  <= PW'(c_cand_reg[2*p+1].un) * PW'(c_cand_reg[2*p].ud);
            d_pa_reg[p]  <= PW'(c_cand_reg[2*p].un) * PW'(c_cand_reg[2*p+1].ud);
            e_win_reg[p] <= e_win_next[p];
            f_win_reg[p] <= e_win_reg[p];
        end
        f_pb_reg  <= PW'(e_win_reg[1].un) * PW'(e_win_reg[0].ud);
        f_pa_reg  <= PW'(e_win_reg[0].un) * PW'(e_win_reg[1].ud);
        g_win_reg <= g_win_next;
    end

endmodule

[hw/rtl/sbfh_checker.sv]
// Port-level checker for the segment/box first-hit block, with its bind.
`include "segment_box_first_hit_assert.svh"

module sbfh_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           start,
    input logic           busy,
    input logic           done,
    input sbfh_pkg::res_t res
);

    `SBFH_NEVER(a_no_busy, busy)
    `SBFH_ASSERT(a_lat, (start && !busy) |-> ##(sbfh_pkg::LATENCY) done)
    `SBFH_ASSERT(a_no_extra, !start |-> ##(sbfh_pkg::LATENCY) !done)
    `SBFH_NEVER(a_miss_zero, done && !res.hit && (res.hit_t != '0 || res.hit_side != '0))
    `SBFH_NEVER(a_t_max, done && res.hit_t[sbfh_pkg::T_W-1] && (res.hit_t[sbfh_pkg::T_W-2:0] != '0))

endmodule

bind segment_box_first_hit sbfh_checker u_sbfh_checker (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .done  (done),
    .res   (res)
);
